### rtl/stereo_gain_swap_saturate_macros.svh
// Assertion macros used by the checker module of the stereo gain block.
`ifndef STEREO_GAIN_SWAP_SATURATE_MACROS_SVH
`define STEREO_GAIN_SWAP_SATURATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define SGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/sgs_pkg.sv
// Package: widths, constants, register codes and types of the stereo gain block.
`default_nettype none
package sgs_pkg;

  localparam int GAIN_BITS_DEF = 10;
  localparam int SAMPLE_W      = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;
  localparam int ECHO_GAIN_W   = 7;
  localparam int ECHO_MAG_W    = 15;
  localparam int PIPE_DEPTH    = 9;

  localparam int WIDE_MAX   = 32767;
  localparam int NARROW_MAX = 255;
  localparam int PERCENT    = 100;

  localparam int RST_GAIN      = 100;
  localparam int RST_ECHO_GAIN = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE      = 3'd0,
    CFG_STEREO    = 3'd1,
    CFG_SWAP      = 3'd2,
    CFG_GAIN_L    = 3'd3,
    CFG_GAIN_R    = 3'd4,
    CFG_ECHO_EN   = 3'd5,
    CFG_ECHO_GAIN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                   wide;
    logic                   stereo;
    logic                   swap;
    logic                   echo_en;
    logic [ECHO_GAIN_W-1:0] echo_gain;
  } cfg_t;

  typedef struct packed {
    logic                   wide;
    logic                   echo_en;
    logic [ECHO_GAIN_W-1:0] echo_gain;
  } side_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
  } pair_t;

endpackage
`default_nettype wire

### rtl/sgs_cfg.sv
// Configuration register file of the stereo gain block.
`default_nettype none
module sgs_cfg import sgs_pkg::*; #(
  parameter int GAIN_BITS = GAIN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o,
  output logic [GAIN_BITS-1:0]       gain_left_o,
  output logic [GAIN_BITS-1:0]       gain_right_o
);

  cfg_t                 cfg_q, cfg_d;
  logic [GAIN_BITS-1:0] gain_l_q, gain_l_d;
  logic [GAIN_BITS-1:0] gain_r_q, gain_r_d;
  logic [15:0]          data_ext;
  logic [GAIN_BITS-1:0] gain_wr;

  assign cfg_ready_o = 1'b1;
  assign data_ext    = {{(16-CFG_DATA_W){1'b0}}, cfg_data_i};
  assign gain_wr     = data_ext[GAIN_BITS-1:0];

  always_comb begin
    cfg_d    = cfg_q;
    gain_l_d = gain_l_q;
    gain_r_d = gain_r_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDE:      cfg_d.wide      = cfg_data_i[0];
        CFG_STEREO:    cfg_d.stereo    = cfg_data_i[0];
        CFG_SWAP:      cfg_d.swap      = cfg_data_i[0];
        CFG_GAIN_L:    gain_l_d        = gain_wr;
        CFG_GAIN_R:    gain_r_d        = gain_wr;
        CFG_ECHO_EN:   cfg_d.echo_en   = cfg_data_i[0];
        CFG_ECHO_GAIN: cfg_d.echo_gain = cfg_data_i[ECHO_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide      <= 1'b1;
      cfg_q.stereo    <= 1'b1;
      cfg_q.swap      <= 1'b0;
      cfg_q.echo_en   <= 1'b0;
      cfg_q.echo_gain <= ECHO_GAIN_W'(RST_ECHO_GAIN);
      gain_l_q        <= GAIN_BITS'(RST_GAIN);
      gain_r_q        <= GAIN_BITS'(RST_GAIN);
    end else begin
      cfg_q    <= cfg_d;
      gain_l_q <= gain_l_d;
      gain_r_q <= gain_r_d;
    end
  end

  assign cfg_o        = cfg_q;
  assign gain_left_o  = gain_l_q;
  assign gain_right_o = gain_r_q;

endmodule
`default_nettype wire

### rtl/sgs_pipe_ctrl.sv
// Valid bits and per-stage load enables of the item pipeline.
`default_nettype none
module sgs_pipe_ctrl import sgs_pkg::*; #(
  parameter int DEPTH = PIPE_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic [DEPTH-1:0] en_o
);

  logic [DEPTH-1:0] valid_q, valid_d;
  logic [DEPTH-1:0] en;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[DEPTH-1] = !valid_q[DEPTH-1] || out_ready_i;
    for (int k = DEPTH-2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < DEPTH; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[DEPTH-1];

endmodule
`default_nettype wire

### rtl/sgs_scale_sat.sv
// Four-stage lane: magnitude times percent gain, divide by 100, saturate, sign.
`default_nettype none
module sgs_scale_sat import sgs_pkg::*; #(
  parameter int MAG_W  = SAMPLE_W,
  parameter int GAIN_W = GAIN_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic [3:0]                 en_i,
  input  wire logic [MAG_W-1:0]           mag_i,
  input  wire logic                       neg_i,
  input  wire logic [GAIN_W-1:0]          gain_i,
  input  wire logic                       wide_i,
  input  wire logic                       keep_i,
  output logic signed [SAMPLE_W-1:0]      val_o
);

  localparam int PW = MAG_W + GAIN_W;
  localparam int RW = PW - 6;
  localparam int CW = (RW > SAMPLE_W) ? RW : SAMPLE_W;
  localparam longint unsigned RECIP_L = (64'd1 << PW) / PERCENT;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [PW-1:0]          prod_q, prod_d;
  logic                   neg1_q, neg2_q, neg3_q;
  logic [PW-1:0]          num_q;
  logic [PW+RW-1:0]       rp_q, rp_d;
  logic [RW-1:0]          quo_q, quo_d;
  logic [RW-1:0]          q0;
  logic [PW-1:0]          rem;
  logic [CW-1:0]          q_ext, lim, sat;
  logic [SAMPLE_W-1:0]    sat_s;
  logic signed [SAMPLE_W-1:0] val_q, val_d;

  assign prod_d = PW'(mag_i) * PW'(gain_i);
  assign rp_d   = (PW+RW)'(prod_q) * (PW+RW)'(RECIP);

  // Reciprocal estimate is exact or one short; one compare fixes it.
  assign q0    = rp_q[PW+RW-1:PW];
  assign rem   = num_q - PW'(q0) * PW'(PERCENT);
  assign quo_d = (rem >= PW'(PERCENT)) ? RW'(q0 + RW'(1)) : q0;

  always_comb begin
    q_ext = CW'(quo_q);
    lim   = wide_i ? CW'(WIDE_MAX) : CW'(NARROW_MAX);
    sat   = (q_ext > lim) ? lim : q_ext;
    sat_s = sat[SAMPLE_W-1:0];
    if (!keep_i || (neg3_q && !wide_i)) begin
      val_d = '0;
    end else if (neg3_q) begin
      val_d = -$signed(sat_s);
    end else begin
      val_d = $signed(sat_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      neg1_q <= neg_i;
    end
    if (en_i[1]) begin
      num_q  <= prod_q;
      rp_q   <= rp_d;
      neg2_q <= neg1_q;
    end
    if (en_i[2]) begin
      quo_q  <= quo_d;
      neg3_q <= neg2_q;
    end
    if (en_i[3]) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

### rtl/stereo_gain_swap_saturate.sv
// Top level of the stereo PCM gain, swap, saturate and echo-copy block.
//
// Channels: cfg (valid/ready, index and data) writes the seven control
// registers; it is always ready and should be used only while the block is
// idle. in (valid/ready) carries one frame per item: left and right sample.
// out (valid/ready) carries one result per frame: both scaled samples, both
// echo copies and echo_valid.
// Pipeline: nine register stages. Throughput: one item per cycle, sustained
// as long as the receiver does not stall the output.
// Front stage reads and swaps samples and picks gains, then two four-stage
// lanes (multiply, reciprocal multiply, correction, saturate) do the main
// scaling, and two more do the echo copy.
// Reset clears all valid bits and loads the register defaults: 16-bit signed,
// stereo, no swap, gains 100, echo off with gain 50.
// When the receiver stalls the last stage holds its result; earlier stages
// keep filling empty slots, so input is refused only once every stage holds
// an item.
`default_nettype none
module stereo_gain_swap_saturate import sgs_pkg::*; #(
  parameter int GAIN_BITS = GAIN_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] right_sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0]      left_out_o,
  output logic signed [SAMPLE_W-1:0]      right_out_o,
  output logic signed [SAMPLE_W-1:0]      echo_left_o,
  output logic signed [SAMPLE_W-1:0]      echo_right_o,
  output logic                            echo_valid_o
);

  cfg_t                   cfg;
  logic [GAIN_BITS-1:0]   gain_l, gain_r;
  logic [PIPE_DEPTH-1:0]  en;

  sgs_cfg #(.GAIN_BITS(GAIN_BITS)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .gain_left_o  (gain_l),
    .gain_right_o (gain_r)
  );

  sgs_pipe_ctrl #(.DEPTH(PIPE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  // Front stage: sample decode, swap, gain selection.
  logic [SAMPLE_W-1:0]  mag_l, mag_r;
  logic                 neg_l, neg_r;
  logic [GAIN_BITS:0]   gain_sum;
  logic [GAIN_BITS-1:0] gain_avg;
  logic [SAMPLE_W-1:0]  mag_a_q, mag_a_d, mag_b_q, mag_b_d;
  logic                 neg_a_q, neg_a_d, neg_b_q, neg_b_d;
  logic [GAIN_BITS-1:0] gain_a_q, gain_a_d, gain_b_q, gain_b_d;
  side_t                side_q [PIPE_DEPTH];
  side_t                side_d;

  always_comb begin
    if (cfg.wide) begin
      neg_l = left_sample_i[SAMPLE_W-1];
      neg_r = right_sample_i[SAMPLE_W-1];
      mag_l = neg_l ? SAMPLE_W'(-left_sample_i)  : SAMPLE_W'(left_sample_i);
      mag_r = neg_r ? SAMPLE_W'(-right_sample_i) : SAMPLE_W'(right_sample_i);
    end else begin
      neg_l = 1'b0;
      neg_r = 1'b0;
      mag_l = {8'b0, left_sample_i[7:0]};
      mag_r = {8'b0, right_sample_i[7:0]};
    end
  end

  assign gain_sum = {1'b0, gain_l} + {1'b0, gain_r};
  assign gain_avg = gain_sum[GAIN_BITS:1];

  always_comb begin
    mag_a_d  = mag_l;
    neg_a_d  = neg_l;
    mag_b_d  = mag_r;
    neg_b_d  = neg_r;
    gain_a_d = gain_l;
    gain_b_d = gain_r;
    if (!cfg.stereo) begin
      gain_a_d = gain_avg;
      gain_b_d = gain_avg;
    end else if (cfg.swap) begin
      mag_a_d = mag_r;
      neg_a_d = neg_r;
      mag_b_d = mag_l;
      neg_b_d = neg_l;
    end
  end

  assign side_d.wide      = cfg.wide;
  assign side_d.echo_en   = cfg.echo_en;
  assign side_d.echo_gain = cfg.echo_gain;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_a_q   <= mag_a_d;
      neg_a_q   <= neg_a_d;
      mag_b_q   <= mag_b_d;
      neg_b_q   <= neg_b_d;
      gain_a_q  <= gain_a_d;
      gain_b_q  <= gain_b_d;
      side_q[0] <= side_d;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // Main lanes, stages 1 to 4.
  logic signed [SAMPLE_W-1:0] main_a, main_b;

  sgs_scale_sat #(.MAG_W(SAMPLE_W), .GAIN_W(GAIN_BITS)) u_main_a (
    .clk_i  (clk_i),
    .en_i   (en[4:1]),
    .mag_i  (mag_a_q),
    .neg_i  (neg_a_q),
    .gain_i (gain_a_q),
    .wide_i (side_q[3].wide),
    .keep_i (1'b1),
    .val_o  (main_a)
  );

  sgs_scale_sat #(.MAG_W(SAMPLE_W), .GAIN_W(GAIN_BITS)) u_main_b (
    .clk_i  (clk_i),
    .en_i   (en[4:1]),
    .mag_i  (mag_b_q),
    .neg_i  (neg_b_q),
    .gain_i (gain_b_q),
    .wide_i (side_q[3].wide),
    .keep_i (1'b1),
    .val_o  (main_b)
  );

  // Echo lanes, stages 5 to 8, fed by the magnitude of the main results.
  logic [ECHO_MAG_W-1:0] emag_a, emag_b;
  logic [SAMPLE_W-1:0]   abs_a, abs_b;
  logic signed [SAMPLE_W-1:0] echo_a, echo_b;

  assign abs_a  = main_a[SAMPLE_W-1] ? SAMPLE_W'(-main_a) : SAMPLE_W'(main_a);
  assign abs_b  = main_b[SAMPLE_W-1] ? SAMPLE_W'(-main_b) : SAMPLE_W'(main_b);
  assign emag_a = abs_a[ECHO_MAG_W-1:0];
  assign emag_b = abs_b[ECHO_MAG_W-1:0];

  sgs_scale_sat #(.MAG_W(ECHO_MAG_W), .GAIN_W(ECHO_GAIN_W)) u_echo_a (
    .clk_i  (clk_i),
    .en_i   (en[8:5]),
    .mag_i  (emag_a),
    .neg_i  (main_a[SAMPLE_W-1]),
    .gain_i (side_q[4].echo_gain),
    .wide_i (side_q[7].wide),
    .keep_i (side_q[7].echo_en),
    .val_o  (echo_a)
  );

  sgs_scale_sat #(.MAG_W(ECHO_MAG_W), .GAIN_W(ECHO_GAIN_W)) u_echo_b (
    .clk_i  (clk_i),
    .en_i   (en[8:5]),
    .mag_i  (emag_b),
    .neg_i  (main_b[SAMPLE_W-1]),
    .gain_i (side_q[4].echo_gain),
    .wide_i (side_q[7].wide),
    .keep_i (side_q[7].echo_en),
    .val_o  (echo_b)
  );

  // Main results ride alongside the echo lanes.
  pair_t main_q [5:8];
  pair_t main_d;

  assign main_d.a = main_a;
  assign main_d.b = main_b;

  always_ff @(posedge clk_i) begin
    if (en[5]) main_q[5] <= main_d;
    for (int k = 6; k <= 8; k++) begin
      if (en[k]) main_q[k] <= main_q[k-1];
    end
  end

  assign left_out_o   = main_q[8].a;
  assign right_out_o  = main_q[8].b;
  assign echo_left_o  = echo_a;
  assign echo_right_o = echo_b;
  assign echo_valid_o = side_q[8].echo_en;

endmodule
`default_nettype wire

### rtl/sgs_checker.sv
// Port-level checker of the stereo gain block, bound to the top level.
`default_nettype none
`include "stereo_gain_swap_saturate_macros.svh"
module sgs_checker import sgs_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic signed [SAMPLE_W-1:0] left_out_o,
  input wire logic signed [SAMPLE_W-1:0] right_out_o,
  input wire logic signed [SAMPLE_W-1:0] echo_left_o,
  input wire logic signed [SAMPLE_W-1:0] echo_right_o,
  input wire logic                       echo_valid_o
);

  // A stalled result stays put.
  `SGS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(left_out_o) && $stable(right_out_o) &&
    $stable(echo_left_o) && $stable(echo_right_o) && $stable(echo_valid_o))

  // Input is refused only when the full pipeline is backed up.
  `SGS_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // Echo fields are zero when the echo copy is off.
  `SGS_ASSERT_IMP(a_echo_off, clk_i, rst_ni, out_valid_o && !echo_valid_o,
    echo_left_o == '0 && echo_right_o == '0)

  // Saturation never yields the most negative code.
  `SGS_ASSERT_IMP(a_no_min, clk_i, rst_ni, out_valid_o,
    left_out_o != 16'h8000 && right_out_o != 16'h8000 &&
    echo_left_o != 16'h8000 && echo_right_o != 16'h8000)

endmodule

bind stereo_gain_swap_saturate sgs_checker u_sgs_checker (.*);
`default_nettype wire

### sim/stereo_gain_swap_saturate_tb.sv
// Self-checking testbench for the stereo gain, swap, saturate and echo-copy block.
module stereo_gain_swap_saturate_tb import sgs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  typedef logic [0:6][CFG_DATA_W-1:0] reg_image_t;

  typedef struct packed {
    logic                     wide;
    logic                     stereo;
    logic                     swap;
    logic [GAIN_BITS_DEF-1:0] gain_l;
    logic [GAIN_BITS_DEF-1:0] gain_r;
    logic                     echo_en;
    logic [ECHO_GAIN_W-1:0]   echo_gain;
  } mix_regs_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic signed [SAMPLE_W-1:0] echo_left;
    logic signed [SAMPLE_W-1:0] echo_right;
    logic                       echo_valid;
  } frame_out_t;

  typedef struct packed {
    logic [3:0]                 cfg;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       known;
    frame_out_t                 want;
  } drill_row_t;

  localparam frame_out_t NO_WANT = '0;

  // register order: wide, stereo, swap, gain_l, gain_r, echo_en, echo_gain
  localparam reg_image_t DRILL_CFG [13] = '{
    '{10'd1, 10'd1, 10'd0, 10'd100, 10'd100, 10'd0, 10'd50},
    '{10'd1, 10'd1, 10'd1, 10'd100, 10'd100, 10'd0, 10'd50},
    '{10'd1, 10'd1, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd50},
    '{10'd1, 10'd0, 10'd1, 10'd1023, 10'd0, 10'd0, 10'd50},
    '{10'd1, 10'd1, 10'd0, 10'd200, 10'd50, 10'd1, 10'd100},
    '{10'd1, 10'd1, 10'd0, 10'd100, 10'd100, 10'd1, 10'd1023},
    '{10'd1, 10'd1, 10'd0, 10'd100, 10'd100, 10'd1, 10'd0},
    '{10'd0, 10'd1, 10'd0, 10'd100, 10'd100, 10'd0, 10'd50},
    '{10'd0, 10'd1, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd50},
    '{10'd0, 10'd1, 10'd1, 10'd37, 10'd250, 10'd1, 10'd33},
    '{10'd0, 10'd0, 10'd1, 10'd1022, 10'd1023, 10'd1, 10'd127},
    '{10'd1, 10'd0, 10'd0, 10'd0, 10'd1, 10'd0, 10'd50},
    '{10'h3FE, 10'h3FF, 10'h3FF, 10'd512, 10'd3, 10'h3FF, 10'h3E5}
  };

  localparam drill_row_t DRILL [21] = '{
    '{4'd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{4'd0, 16'sh7FFF, 16'sh8000, 1'b1,
      '{16'sd32767, -16'sd32767, 16'sd0, 16'sd0, 1'b0}},
    '{4'd0, -16'sd1, 16'sd1, 1'b1, '{-16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0}},
    '{4'd1, 16'sd1234, -16'sd5678, 1'b1,
      '{-16'sd5678, 16'sd1234, 16'sd0, 16'sd0, 1'b0}},
    '{4'd2, 16'sh7FFF, 16'sh7FFF, 1'b1, '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{4'd2, 16'sh8000, 16'sh8000, 1'b1, '{-16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{4'd2, -16'sd7, 16'sd3, 1'b0, NO_WANT},
    '{4'd3, 16'sd100, -16'sd100, 1'b0, NO_WANT},
    '{4'd3, 16'sh8000, 16'sh7FFF, 1'b0, NO_WANT},
    '{4'd4, 16'sd20000, -16'sd20000, 1'b0, NO_WANT},
    '{4'd4, -16'sd123, 16'sd77, 1'b0, NO_WANT},
    '{4'd5, 16'sh7FFF, 16'sh8000, 1'b1,
      '{16'sd32767, -16'sd32767, 16'sd32767, -16'sd32767, 1'b1}},
    '{4'd6, 16'sd500, -16'sd500, 1'b1, '{16'sd500, -16'sd500, 16'sd0, 16'sd0, 1'b1}},
    '{4'd7, 16'shFFFF, 16'sh1280, 1'b1, '{16'sd255, 16'sd128, 16'sd0, 16'sd0, 1'b0}},
    '{4'd7, 16'sh8000, 16'sh7F7F, 1'b1, '{16'sd0, 16'sd127, 16'sd0, 16'sd0, 1'b0}},
    '{4'd8, 16'sh00FF, 16'sh7F01, 1'b1, '{16'sd255, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{4'd9, 16'sd200, 16'sd3, 1'b0, NO_WANT},
    '{4'd9, 16'shFF00, 16'sh00FF, 1'b0, NO_WANT},
    '{4'd10, 16'sh5501, 16'shAAFF, 1'b0, NO_WANT},
    '{4'd11, 16'sh7FFF, 16'sh8000, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{4'd12, 16'shA5C3, 16'sh5A3C, 1'b0, NO_WANT}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] left_sample_i = '0;
  logic signed [SAMPLE_W-1:0] right_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out_o;
  logic signed [SAMPLE_W-1:0] right_out_o;
  logic signed [SAMPLE_W-1:0] echo_left_o;
  logic signed [SAMPLE_W-1:0] echo_right_o;
  logic                       echo_valid_o;

  mix_regs_t live_regs = '{1'b1, 1'b1, 1'b0, GAIN_BITS_DEF'(RST_GAIN),
                           GAIN_BITS_DEF'(RST_GAIN), 1'b0, ECHO_GAIN_W'(RST_ECHO_GAIN)};
  frame_out_t pending_frames [$];
  int  fails = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  stereo_gain_swap_saturate uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .echo_left_o    (echo_left_o),
    .echo_right_o   (echo_right_o),
    .echo_valid_o   (echo_valid_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int clip_scaled(int sample, int gain, bit wide);
    int v;
    v = (sample * gain) / PERCENT;
    if (wide) begin
      if (v > WIDE_MAX) v = WIDE_MAX;
      else if (v < -WIDE_MAX) v = -WIDE_MAX;
    end else begin
      if (v > NARROW_MAX) v = NARROW_MAX;
      else if (v < 0) v = 0;
    end
    return v;
  endfunction

  function automatic frame_out_t predict_frame(mix_regs_t m, logic signed [SAMPLE_W-1:0] l,
                                               logic signed [SAMPLE_W-1:0] r);
    int a, b, ga, gb, t, oa, ob;
    frame_out_t f;
    a = m.wide ? int'(l) : int'(l[7:0]);
    b = m.wide ? int'(r) : int'(r[7:0]);
    ga = int'(m.gain_l);
    gb = int'(m.gain_r);
    if (m.stereo) begin
      if (m.swap) begin
        t = a;
        a = b;
        b = t;
      end
    end else begin
      ga = (ga + gb) / 2;
      gb = ga;
    end
    oa = clip_scaled(a, ga, m.wide);
    ob = clip_scaled(b, gb, m.wide);
    f.left_out  = 16'(oa);
    f.right_out = 16'(ob);
    if (m.echo_en) begin
      f.echo_left  = 16'(clip_scaled(oa, int'(m.echo_gain), m.wide));
      f.echo_right = 16'(clip_scaled(ob, int'(m.echo_gain), m.wide));
      f.echo_valid = 1'b1;
    end else begin
      f.echo_left  = '0;
      f.echo_right = '0;
      f.echo_valid = 1'b0;
    end
    return f;
  endfunction

  function automatic int pick_gap();
    int p;
    p = int'($urandom_range(0, 99));
    if (tx_calm || p < 60) return 0;
    if (p < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      3: return {8'($urandom), 8'hFF};
      4: return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'd100;
      3: return 10'($urandom_range(0, 200));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic reg_image_t random_settings();
    reg_image_t v;
    v[CFG_WIDE]    = 10'($urandom);
    v[CFG_STEREO]  = 10'($urandom);
    v[CFG_SWAP]    = 10'($urandom);
    v[CFG_GAIN_L]  = pick_gain();
    v[CFG_GAIN_R]  = pick_gain();
    v[CFG_ECHO_EN] = 10'($urandom);
    case ($urandom_range(0, 4))
      0: v[CFG_ECHO_GAIN] = 10'd0;
      1: v[CFG_ECHO_GAIN] = 10'd100;
      2: v[CFG_ECHO_GAIN] = 10'd127;
      3: v[CFG_ECHO_GAIN] = 10'($urandom);
      default: v[CFG_ECHO_GAIN] = 10'($urandom_range(0, 100));
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d,
                           input int gap);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WIDE:      live_regs.wide      = d[0];
      CFG_STEREO:    live_regs.stereo    = d[0];
      CFG_SWAP:      live_regs.swap      = d[0];
      CFG_GAIN_L:    live_regs.gain_l    = d[GAIN_BITS_DEF-1:0];
      CFG_GAIN_R:    live_regs.gain_r    = d[GAIN_BITS_DEF-1:0];
      CFG_ECHO_EN:   live_regs.echo_en   = d[0];
      CFG_ECHO_GAIN: live_regs.echo_gain = d[ECHO_GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // block must be empty before its registers change
  task automatic settle_and_write(input reg_image_t v);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(CFG_NONE, 10'($urandom), 0);
    write_reg(CFG_WIDE, v[CFG_WIDE], pick_gap());
    write_reg(CFG_STEREO, v[CFG_STEREO], pick_gap());
    write_reg(CFG_SWAP, v[CFG_SWAP], pick_gap());
    write_reg(CFG_GAIN_L, v[CFG_GAIN_L], pick_gap());
    write_reg(CFG_GAIN_R, v[CFG_GAIN_R], pick_gap());
    write_reg(CFG_ECHO_EN, v[CFG_ECHO_EN], pick_gap());
    write_reg(CFG_ECHO_GAIN, v[CFG_ECHO_GAIN], pick_gap());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input frame_out_t want, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_frames.push_back(want);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 50))
                                                 : int'($urandom_range(0, 2));
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected item: left_out %0d right_out %0d", left_out_o, right_out_o);
        fails++;
      end else begin
        want = pending_frames.pop_front();
        if (left_out_o !== want.left_out) begin
          $error("left_out expected %0d got %0d", want.left_out, left_out_o);
          fails++;
        end
        if (right_out_o !== want.right_out) begin
          $error("right_out expected %0d got %0d", want.right_out, right_out_o);
          fails++;
        end
        if (echo_left_o !== want.echo_left) begin
          $error("echo_left expected %0d got %0d", want.echo_left, echo_left_o);
          fails++;
        end
        if (echo_right_o !== want.echo_right) begin
          $error("echo_right expected %0d got %0d", want.echo_right, echo_right_o);
          fails++;
        end
        if (echo_valid_o !== want.echo_valid) begin
          $error("echo_valid expected %0b got %0b", want.echo_valid, echo_valid_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [3:0]                 cur_cfg;
    logic signed [SAMPLE_W-1:0] l, r;
    frame_out_t                 want;
    int                         sent, span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_cfg = 4'd0;
    foreach (DRILL[k]) begin
      if (DRILL[k].cfg != cur_cfg) begin
        settle_and_write(DRILL_CFG[DRILL[k].cfg]);
        cur_cfg = DRILL[k].cfg;
      end
      want = DRILL[k].known ? DRILL[k].want
                            : predict_frame(live_regs, DRILL[k].left, DRILL[k].right);
      send_frame(DRILL[k].left, DRILL[k].right, want, pick_gap());
    end

    sent = 0;
    while (sent < ITEMS) begin
      settle_and_write(random_settings());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      span = int'($urandom_range(60, 260));
      repeat (span) begin
        l = pick_sample();
        r = pick_sample();
        send_frame(l, r, predict_frame(live_regs, l, r), pick_gap());
      end
      sent += span;
    end

    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
